// ===== src/dls_pkg.sv =====
// Shared types and constants of the dense layer with sigmoid activation.
`timescale 1ns / 1ps

package dls_pkg;

    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 12;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = 36;
    localparam int POS_W     = 8;
    localparam int CFG_W     = 5;
    localparam int UIDX_W    = 4;
    localparam int TAB_AW    = 8;
    localparam int TAB_DEPTH = 256;
    localparam int QUOT_W    = 17;

    // e^-(1/32) in Q0.32.
    localparam logic [31:0] EXP_STEP = 32'd4162825044;
    localparam logic [CFG_W-1:0] UNIT_COUNT_RESET = 5'd16;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_ELEMENT = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        logic [UIDX_W-1:0]        unit_index;
        logic signed [DATA_W-1:0] weighted_sum;
        logic [DATA_W-1:0]        activation;
        logic                     last_unit;
    } t_out_item;

    typedef struct packed {
        logic wr_weight;
        logic wr_bias;
        logic mac_issue;
        logic acc_read;
        logic first;
    } t_store_ctl;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_SUM,
        ST_EMIT_OUT
    } t_state;

    typedef enum logic [3:0] {
        TB_LOAD_HI,
        TB_DIV_HI,
        TB_WR_HI,
        TB_DIV_LO,
        TB_WR_LO,
        TB_MUL_A,
        TB_MUL_B,
        TB_MUL_C,
        TB_DONE
    } t_tab_state;

endpackage

// ===== src/dls_stream_if.sv =====
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps

interface dls_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/dense_layer_sigmoid_forward_top.sv =====
// Top level of the fully connected layer with sigmoid activation.
// Weight and bias words are taken in idle; an element word occupies the block while the single
// shared multiply-accumulate works through the units in use, one unit a cycle, and drains.
// A last element then emits one result per unit (accumulator read, table read), waiting while
// the output is not ready. After reset a serial divider builds the sigmoid table; no input word
// is taken until then. Accumulators read as zero until written; configuration is free.
`timescale 1ns / 1ps

module dense_layer_sigmoid_forward_top #(
    parameter int MAX_UNITS  = 16,
    parameter int MAX_INPUTS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    dls_stream_if.sink   i_cfg,
    dls_stream_if.sink   i_in,
    dls_stream_if.source o_out
);
    import dls_pkg::*;

    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int IDX_W = POS_W + CNT_W + 1;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]         r_unit_count;
    logic [CNT_W-1:0]         r_j;
    logic [CNT_W-1:0]         r_n;
    logic [IDX_W-1:0]         r_base;
    logic signed [DATA_W-1:0] r_val;
    logic                     r_first;
    logic                     r_last;
    logic signed [DATA_W-1:0] r_sum;
    logic                     r_out_valid;
    t_out_item                r_out;

    t_in_item                 in_item;
    logic                     in_acc;
    logic                     out_load;
    logic                     unit_is_last;
    logic [CNT_W-1:0]         units_in_use;
    t_store_ctl               store_ctl;
    logic                     store_busy;
    logic signed [DATA_W-1:0] store_sum;
    logic                     tab_ready;
    logic                     tab_rd_en;
    logic [TAB_AW-1:0]        tab_rd_addr;
    logic [DATA_W-1:0]        tab_rd_data;
    logic [IDX_W-1:0]         widx;

    assign in_item      = i_in.data;
    assign in_acc       = i_in.valid && i_in.ready;
    assign unit_is_last = (r_j == r_n - CNT_W'(1));
    assign out_load     = (r_state == ST_EMIT_OUT) && (!r_out_valid || o_out.ready);
    assign widx         = r_base + IDX_W'(r_j);

    always_comb begin
        if (r_unit_count == '0) begin
            units_in_use = CNT_W'(1);
        end else if (int'(r_unit_count) > MAX_UNITS) begin
            units_in_use = CNT_W'(MAX_UNITS);
        end else begin
            units_in_use = CNT_W'(r_unit_count);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (tab_ready) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc && in_item.cmd == CMD_ELEMENT) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (unit_is_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!store_busy) n_state = r_last ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:  n_state = ST_EMIT_SUM;
            ST_EMIT_SUM: n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (out_load) n_state = unit_is_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready          = (r_state == ST_IDLE);
        store_ctl.wr_weight = in_acc && (in_item.cmd == CMD_WEIGHT);
        store_ctl.wr_bias   = in_acc && (in_item.cmd == CMD_BIAS);
        store_ctl.mac_issue = (r_state == ST_MAC);
        store_ctl.acc_read  = (r_state == ST_EMIT_RD);
        store_ctl.first     = r_first;
        tab_rd_en           = (r_state == ST_EMIT_SUM);
        // Table index is the saturated sum offset to unsigned, top eight bits.
        tab_rd_addr         = {~store_sum[DATA_W-1], store_sum[DATA_W-2:DATA_W-TAB_AW]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_unit_count <= UNIT_COUNT_RESET;
            r_j          <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) r_unit_count <= i_cfg.data;
            case (r_state)
                ST_IDLE:     r_j <= '0;
                ST_MAC:      r_j <= r_j + CNT_W'(1);
                ST_DRAIN:    r_j <= '0;
                ST_EMIT_OUT: begin
                    if (out_load) r_j <= r_j + CNT_W'(1);
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_item.cmd == CMD_ELEMENT) begin
            r_val   <= in_item.value;
            r_first <= (in_item.position == '0);
            r_last  <= in_item.last;
            r_n     <= units_in_use;
            r_base  <= IDX_W'(in_item.position) * IDX_W'(units_in_use);
        end
        if (r_state == ST_EMIT_SUM) r_sum <= store_sum;
        if (out_load) begin
            r_out.unit_index   <= UIDX_W'(r_j);
            r_out.weighted_sum <= r_sum;
            r_out.activation   <= tab_rd_data;
            r_out.last_unit    <= unit_is_last;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    dls_store #(
        .MAX_UNITS  (MAX_UNITS),
        .MAX_INPUTS (MAX_INPUTS),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (store_ctl),
        .i_item      (in_item),
        .i_mac_value (r_val),
        .i_unit      (r_j),
        .i_widx      (widx),
        .o_busy      (store_busy),
        .o_sum       (store_sum)
    );

    dls_sig_table u_sig_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (tab_rd_en),
        .i_rd_addr (tab_rd_addr),
        .o_rd_data (tab_rd_data),
        .o_ready   (tab_ready)
    );

    // Emission must not read an accumulator before the last write of the pass lands.
    a_drained_before_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD) |-> !store_busy)
        else $error("accumulator read while the update pipeline is busy");

    a_unit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC || r_state == ST_EMIT_RD) |-> (r_j < r_n))
        else $error("unit counter beyond the units in use");

    a_no_word_before_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tab_ready |-> !i_in.ready)
        else $error("input word taken before the sigmoid table is built");

    a_emit_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && !store_busy && !r_last) |=> (r_state == ST_IDLE))
        else $error("emission started without a last element");

endmodule

// ===== src/dls_sig_table.sv =====
// Sigmoid table memory, built after reset by a shared divider and multiplier.
`timescale 1ns / 1ps

module dls_sig_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [dls_pkg::TAB_AW-1:0] i_rd_addr,
    output logic [dls_pkg::DATA_W-1:0] o_rd_data,
    output logic                       o_ready
);
    import dls_pkg::*;

    localparam int DSH_W = 33 + QUOT_W - 1;
    localparam int REM_W = DSH_W + 1;

    t_tab_state r_state;
    t_tab_state n_state;

    logic [6:0]        r_k;
    logic [31:0]       r_p;
    logic [4:0]        r_bit;
    logic [DSH_W-1:0]  r_dsh;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [63:0]       r_prod;
    logic [DATA_W-1:0] r_tab_mem [TAB_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [REM_W:0]      trial;
    logic                trial_ok;
    logic [31:0]         half_d;
    logic [64:0]         prod_rnd;
    logic                tab_we;
    logic [TAB_AW-1:0]   tab_addr;
    logic [DATA_W-1:0]   tab_data;

    // Half of the divisor 2^32 + p, rounded down.
    assign half_d   = {1'b1, r_p[31:1]};
    assign trial    = {1'b0, r_rem} - {2'b00, r_dsh};
    assign trial_ok = !trial[REM_W];
    assign prod_rnd = {1'b0, r_prod} + 65'h0_8000_0000;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TB_LOAD_HI: n_state = TB_DIV_HI;
            TB_DIV_HI: begin
                if (r_bit == '0) n_state = TB_WR_HI;
            end
            TB_WR_HI:   n_state = TB_DIV_LO;
            TB_DIV_LO: begin
                if (r_bit == '0) n_state = TB_WR_LO;
            end
            TB_WR_LO:   n_state = TB_MUL_A;
            TB_MUL_A:   n_state = TB_MUL_B;
            TB_MUL_B:   n_state = TB_MUL_C;
            TB_MUL_C: begin
                n_state = (r_k == 7'd127) ? TB_DONE : TB_LOAD_HI;
            end
            TB_DONE:    n_state = TB_DONE;
            default:    n_state = TB_DONE;
        endcase
    end

    // The upper half of the table is written from the high quotient, the
    // lower half mirrors it from the low quotient.
    always_comb begin
        tab_we   = (r_state == TB_WR_HI) || (r_state == TB_WR_LO);
        tab_addr = (r_state == TB_WR_HI) ? {1'b1, r_k} : {1'b0, ~r_k};
        tab_data = r_q[QUOT_W-1] ? {DATA_W{1'b1}} : r_q[DATA_W-1:0];
        o_ready  = (r_state == TB_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TB_LOAD_HI;
            r_k     <= '0;
            r_p     <= EXP_STEP;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                TB_LOAD_HI, TB_WR_HI: r_bit <= 5'(QUOT_W - 1);
                TB_DIV_HI, TB_DIV_LO: r_bit <= r_bit - 5'd1;
                TB_MUL_A:             r_p <= prod_rnd[63:32];
                TB_MUL_C: begin
                    r_p <= prod_rnd[63:32];
                    r_k <= r_k + 7'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TB_LOAD_HI: begin
                r_rem <= (REM_W'(1) << 48) + REM_W'(half_d);
                r_dsh <= {1'b1, r_p, 16'h0000};
            end
            TB_DIV_HI, TB_DIV_LO: begin
                if (trial_ok) r_rem <= trial[REM_W-1:0];
                r_q   <= {r_q[QUOT_W-2:0], trial_ok};
                r_dsh <= r_dsh >> 1;
            end
            TB_WR_HI: begin
                r_rem <= REM_W'({r_p, 16'h0000}) + REM_W'(half_d);
                r_dsh <= {1'b1, r_p, 16'h0000};
            end
            TB_WR_LO, TB_MUL_B: r_prod <= {32'h0, r_p} * {32'h0, EXP_STEP};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) r_tab_mem[tab_addr] <= tab_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd_data <= r_tab_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dls_store.sv =====
// Weight, bias and accumulator memories with the multiply-accumulate pipeline.
`timescale 1ns / 1ps

module dls_store #(
    parameter int MAX_UNITS  = 16,
    parameter int MAX_INPUTS = 16,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dls_pkg::t_store_ctl               i_ctl,
    input  dls_pkg::t_in_item                 i_item,
    input  logic signed [dls_pkg::DATA_W-1:0] i_mac_value,
    input  logic [CNT_W-1:0]                  i_unit,
    input  logic [IDX_W-1:0]                  i_widx,
    output logic                              o_busy,
    output logic signed [dls_pkg::DATA_W-1:0] o_sum
);
    import dls_pkg::*;

    localparam int W_DEPTH = MAX_UNITS * MAX_INPUTS;
    localparam int WA_W    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int UA_W    = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int RND_W   = ACC_W + 1 - FRAC_BITS;

    logic signed [DATA_W-1:0] r_weight_mem [W_DEPTH];
    logic signed [DATA_W-1:0] r_bias_mem   [MAX_UNITS];
    logic signed [ACC_W-1:0]  r_acc_mem    [MAX_UNITS];
    logic [MAX_UNITS-1:0]     r_acc_vld;

    logic signed [DATA_W-1:0] r_w_q;
    logic signed [DATA_W-1:0] r_bias_q;
    logic signed [ACC_W-1:0]  r_acc_q;
    logic                     r_vld_q;
    logic                     r_s1_v;
    logic                     r_s1_inr;
    logic                     r_s1_first;
    logic [UA_W-1:0]          r_s1_unit;
    logic                     r_s2_v;
    logic [UA_W-1:0]          r_s2_unit;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_base;

    logic [UA_W-1:0]         unit_a;
    logic [WA_W-1:0]         widx_a;
    logic                    widx_ok;
    logic                    wpos_ok;
    logic                    bpos_ok;
    logic signed [ACC_W-1:0] acc_eff;
    logic signed [ACC_W-1:0] bias_ext;
    logic [ACC_W:0]          mac_sum;
    logic signed [ACC_W-1:0] acc_next;
    logic [ACC_W:0]          rnd_sum;
    logic [RND_W-1:0]        rnd_q;

    assign unit_a  = i_unit[UA_W-1:0];
    assign widx_a  = i_widx[WA_W-1:0];
    assign widx_ok = int'(i_widx) < W_DEPTH;
    assign wpos_ok = int'(i_item.position) < W_DEPTH;
    assign bpos_ok = int'(i_item.position) < MAX_UNITS;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_weight && wpos_ok) r_weight_mem[WA_W'(i_item.position)] <= i_item.value;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_bias && bpos_ok) r_bias_mem[UA_W'(i_item.position)] <= i_item.value;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v) r_acc_mem[r_s2_unit] <= acc_next;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_issue || i_ctl.acc_read) begin
            r_w_q    <= r_weight_mem[widx_a];
            r_bias_q <= r_bias_mem[unit_a];
            r_acc_q  <= r_acc_mem[unit_a];
        end
        if (i_ctl.mac_issue) begin
            r_s1_inr   <= widx_ok;
            r_s1_first <= i_ctl.first;
            r_s1_unit  <= unit_a;
        end
        if (r_s1_v) begin
            if (r_s1_inr) begin
                r_prod <= r_w_q * i_mac_value;
            end else begin
                r_prod <= '0;
            end
            r_base    <= r_s1_first ? bias_ext : acc_eff;
            r_s2_unit <= r_s1_unit;
        end
    end

    // An accumulator whose flag is clear reads as zero; emission clears the flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
            r_vld_q   <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            r_s1_v <= i_ctl.mac_issue;
            r_s2_v <= r_s1_v;
            if (i_ctl.mac_issue || i_ctl.acc_read) r_vld_q <= r_acc_vld[unit_a];
            if (i_ctl.acc_read) r_acc_vld[unit_a] <= 1'b0;
            if (r_s2_v) r_acc_vld[r_s2_unit] <= 1'b1;
        end
    end

    assign acc_eff  = r_vld_q ? r_acc_q : '0;
    assign bias_ext = {{(ACC_W-DATA_W-FRAC_BITS){r_bias_q[DATA_W-1]}}, r_bias_q,
                       {FRAC_BITS{1'b0}}};
    assign mac_sum  = {r_base[ACC_W-1], r_base}
                    + {{(ACC_W+1-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
            acc_next = mac_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_next = mac_sum[ACC_W-1:0];
        end
    end

    // Round half up to Q4.12, then saturate to the word range.
    assign rnd_sum = {acc_eff[ACC_W-1], acc_eff} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    assign rnd_q   = rnd_sum[ACC_W:FRAC_BITS];

    always_comb begin
        if (!rnd_q[RND_W-1] && (|rnd_q[RND_W-2:DATA_W-1])) begin
            o_sum = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (rnd_q[RND_W-1] && !(&rnd_q[RND_W-2:DATA_W-1])) begin
            o_sum = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            o_sum = rnd_q[DATA_W-1:0];
        end
    end

    assign o_busy = r_s1_v || r_s2_v;

endmodule

// ===== tb/dense_layer_sigmoid_forward_top_tb.sv =====
// Self-checking testbench for the dense layer with sigmoid activation, against its own predictor.
`timescale 1ns / 1ps

module dense_layer_sigmoid_forward_top_tb;
    import dls_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int     CLK_HALF       = 5;
    localparam int     WSTORE         = 256;
    localparam int     NUNITS         = 16;
    localparam int     SETTLE_CYCLES  = 64;
    localparam int     SQUEEZE_CYCLES = 400;
    localparam int     PHASE_WORDS    = 10;
    localparam int     NPHASES        = 6;
    localparam longint ACC_HI         = 64'sd34359738367;
    localparam longint ACC_LO         = -ACC_HI - 1;
    localparam longint SUM_HI         = 32767;
    localparam longint SUM_LO         = -32768;

    typedef struct {
        t_in_item                 word;
        bit                       typed;
        logic signed [DATA_W-1:0] sum;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dls_stream_if #(.T(logic [CFG_W-1:0])) cfg_if ();
    dls_stream_if #(.T(t_in_item))         in_if ();
    dls_stream_if #(.T(t_out_item))        out_if ();

    dense_layer_sigmoid_forward_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted layer state.
    logic signed [DATA_W-1:0] weight_mem [WSTORE];
    logic signed [DATA_W-1:0] bias_mem [NUNITS];
    longint                   acc_mem [NUNITS];
    logic [DATA_W-1:0]        sigmoid_lut [TAB_DEPTH];
    logic [CFG_W-1:0]         units_cfg;
    t_out_item                pending_results [$];

    int mismatches  = 0;
    bit calm        = 1'b0;
    bit squeeze_req = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    // Each entry is the sigmoid at its bin centre, from e^-|x| as successive powers of e^-1/32.
    function automatic void build_sigmoid_lut();
        longint unsigned p, d, hi, lo;
        int k;
        p = 64'(EXP_STEP);
        for (k = 0; k < 128; k++) begin
            d  = (64'd1 << 32) + p;
            hi = ((64'd1 << 48) + d / 2) / d;
            lo = ((p << 16) + d / 2) / d;
            if (hi > 65535) hi = 65535;
            if (lo > 65535) lo = 65535;
            sigmoid_lut[128 + k] = hi[15:0];
            sigmoid_lut[127 - k] = lo[15:0];
            p = (p * 64'(EXP_STEP) + (64'd1 << 31)) >> 32;
            p = (p * 64'(EXP_STEP) + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic void layer_step(input t_in_item w);
        int        n, j, idx;
        longint    acc, prod, s;
        t_out_item r;
        n = (units_cfg == 0) ? 1 : (units_cfg > NUNITS) ? NUNITS : int'(units_cfg);
        case (w.cmd)
            CMD_WEIGHT: weight_mem[w.position] = w.value;
            CMD_BIAS: begin
                if (w.position < NUNITS) bias_mem[w.position[3:0]] = w.value;
            end
            CMD_ELEMENT: begin
                for (j = 0; j < n; j++) begin
                    idx  = j + int'(w.position) * n;
                    // Indexes past the weight store contribute nothing.
                    prod = (idx < WSTORE) ? longint'(weight_mem[idx]) * longint'(w.value) : 0;
                    acc  = (w.position == 0) ? longint'(bias_mem[j]) * (longint'(1) << FRAC_BITS)
                                             : acc_mem[j];
                    acc += prod;
                    if (acc > ACC_HI) acc = ACC_HI;
                    if (acc < ACC_LO) acc = ACC_LO;
                    acc_mem[j] = acc;
                end
                if (w.last) begin
                    for (j = 0; j < n; j++) begin
                        s = (acc_mem[j] + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
                        if (s > SUM_HI) s = SUM_HI;
                        if (s < SUM_LO) s = SUM_LO;
                        r.unit_index   = UIDX_W'(j);
                        r.weighted_sum = DATA_W'(s);
                        r.activation   = sigmoid_lut[TAB_AW'((s - SUM_LO) >> 8)];
                        r.last_unit    = (j == n - 1);
                        pending_results.push_back(r);
                        acc_mem[j] = 0;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item make_word(input logic [1:0] c, input logic [POS_W-1:0] p,
                                           input logic [DATA_W-1:0] v, input logic l);
        t_in_item w;
        w.cmd      = c;
        w.position = p;
        w.value    = v;
        w.last     = l;
        return w;
    endfunction

    function automatic t_dir_row dir_row(input logic [1:0] c, input logic [POS_W-1:0] p,
                                         input logic [DATA_W-1:0] v, input logic l,
                                         input bit typed, input logic [DATA_W-1:0] sum);
        t_dir_row r;
        r.word  = make_word(c, p, v, l);
        r.typed = typed;
        r.sum   = sum;
        return r;
    endfunction

    // Moderate magnitudes half the time so that sums spread over the table, else full range or edge values.
    function automatic logic [DATA_W-1:0] pick_value();
        int v;
        case ($urandom_range(3))
            0: v = $urandom;
            3: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF;
                    1: v = 32'h8000;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = int'($urandom_range(3072)) - 1536;
        endcase
        return v[DATA_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic push_word(input t_in_item w, input bit typed = 1'b0,
                             input logic signed [DATA_W-1:0] want_sum = '0);
        t_out_item e;
        if (!calm && $urandom_range(4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        layer_step(w);
        if (typed) begin
            e = pending_results.pop_back();
            e.weighted_sum = want_sum;
            pending_results.push_back(e);
        end
        @(negedge i_clk);
    endtask

    task automatic write_units(input logic [CFG_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        units_cfg = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic random_phase(input int words);
        int sent, k, e;
        sent = 0;
        while (sent < words) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: begin
                    k = ($urandom_range(3) == 0) ? $urandom_range(16, 1) : $urandom_range(4, 1);
                    for (e = 0; e < k; e++) begin
                        if ($urandom_range(7) == 0) begin
                            push_word(make_word(CMD_WEIGHT, POS_W'($urandom), pick_value(), 1'b0));
                            sent++;
                        end
                        push_word(make_word(CMD_ELEMENT, POS_W'(e), pick_value(), e == k - 1));
                        sent++;
                    end
                end
                6, 7: begin
                    if ($urandom_range(1))
                        push_word(make_word(CMD_WEIGHT, POS_W'($urandom), pick_value(),
                                            1'($urandom)));
                    else if ($urandom_range(3) == 0)
                        push_word(make_word(CMD_BIAS, POS_W'($urandom), pick_value(),
                                            1'($urandom)));
                    else
                        push_word(make_word(CMD_BIAS, POS_W'($urandom_range(NUNITS - 1)),
                                            pick_value(), 1'($urandom)));
                    sent++;
                end
                8: begin
                    if ($urandom_range(1)) begin
                        push_word(make_word(CMD_NONE, POS_W'($urandom), DATA_W'($urandom),
                                            1'($urandom)));
                    end else begin
                        push_word(make_word(CMD_ELEMENT, POS_W'($urandom), pick_value(),
                                            1'($urandom)));
                        sent++;
                    end
                end
                default: begin
                    // A vector that is dropped before its last element.
                    k = $urandom_range(4, 1);
                    for (e = 0; e < k; e++) begin
                        push_word(make_word(CMD_ELEMENT, POS_W'(e), pick_value(), 1'b0));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing outstanding, unit", got.unit_index, -1);
            end else begin
                want = pending_results.pop_front();
                if (got.unit_index != want.unit_index)
                    flag_mismatch("unit_index", got.unit_index, want.unit_index);
                if (got.weighted_sum != want.weighted_sum)
                    flag_mismatch("weighted_sum", got.weighted_sum, want.weighted_sum);
                if (got.activation != want.activation)
                    flag_mismatch("activation", got.activation, want.activation);
                if (got.last_unit != want.last_unit)
                    flag_mismatch("last_unit", got.last_unit, want.last_unit);
            end
        end
    end

    initial begin : result_sink
        int span;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                // Long hold-off so that the block backs up and refuses input words.
                squeeze_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else if (!calm && $urandom_range(5) == 0) begin
                span = $urandom_range(7, 1);
                out_if.ready <= 1'b0;
                repeat (span) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_dir_row rows [$];
        int       i;
        i_rst_n      = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        units_cfg    = UNIT_COUNT_RESET;
        for (i = 0; i < NUNITS; i++) acc_mem[i] = 0;
        build_sigmoid_lut();

        // One unit in use throughout, so every typed row gives a single result.
        rows.push_back(dir_row(CMD_WEIGHT,  8'd0,   16'h1000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_BIAS,    8'd0,   16'h0000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h1000, 1'b1, 1'b1, 16'sd4096));
        rows.push_back(dir_row(CMD_WEIGHT,  8'd0,   16'h7FFF, 1'b1, 1'b0, '0));
        rows.push_back(dir_row(CMD_BIAS,    8'd0,   16'h7FFF, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h7FFF, 1'b1, 1'b1, 16'sh7FFF));
        rows.push_back(dir_row(CMD_WEIGHT,  8'd0,   16'h8000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_BIAS,    8'd0,   16'h8000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h7FFF, 1'b1, 1'b1, 16'sh8000));
        rows.push_back(dir_row(CMD_BIAS,    8'd0,   16'h0000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h8000, 1'b1, 1'b1, 16'sh7FFF));
        rows.push_back(dir_row(CMD_WEIGHT,  8'd0,   16'h0001, 1'b0, 1'b0, '0));
        // Half a step rounds up, minus half rounds to zero.
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h0800, 1'b1, 1'b1, 16'sd1));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'hF800, 1'b1, 1'b1, 16'sd0));
        rows.push_back(dir_row(CMD_NONE,    8'd0,   16'h1234, 1'b1, 1'b0, '0));
        rows.push_back(dir_row(CMD_BIAS,    8'd200, 16'h5555, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_WEIGHT,  8'd1,   16'h2000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd0,   16'h1000, 1'b0, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd1,   16'h1000, 1'b1, 1'b1, 16'sd8193));
        // No element 0 first: the sum starts from the cleared accumulator.
        rows.push_back(dir_row(CMD_ELEMENT, 8'd1,   16'h1000, 1'b1, 1'b1, 16'sd8192));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd255, 16'h4000, 1'b1, 1'b0, '0));
        rows.push_back(dir_row(CMD_WEIGHT,  8'd255, 16'h8000, 1'b1, 1'b0, '0));
        rows.push_back(dir_row(CMD_ELEMENT, 8'd255, 16'hFFFF, 1'b1, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_units(CFG_W'(1));
        // Fill both stores so that no element ever reads an unwritten word.
        for (i = 0; i < WSTORE; i++)
            push_word(make_word(CMD_WEIGHT, POS_W'(i), pick_value(), 1'b0));
        for (i = 0; i < NUNITS; i++)
            push_word(make_word(CMD_BIAS, POS_W'(i), pick_value(), 1'b0));
        foreach (rows[i]) push_word(rows[i].word, rows[i].typed, rows[i].sum);

        for (i = 0; i < NPHASES; i++) begin
            settle();
            case (i)
                0: write_units(CFG_W'(16));
                1: write_units(CFG_W'(0));
                2: write_units(CFG_W'(31));
                3: write_units(CFG_W'(1));
                4: write_units(CFG_W'($urandom_range(15, 2)));
                default: write_units(CFG_W'($urandom_range(31, 1)));
            endcase
            if (i == 0) begin
                squeeze_req = 1'b1;
                // A one-element vector, so that its results back up behind the held output.
                push_word(make_word(CMD_ELEMENT, POS_W'(0), pick_value(), 1'b1));
            end
            if (i == NPHASES - 1) calm = 1'b1;
            random_phase(PHASE_WORDS);
        end
        settle();

        if (mismatches == 0) begin
            $display("dense_layer_sigmoid_forward_top: match");
        end else begin
            $display("dense_layer_sigmoid_forward_top: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(64'd5_000_000);
        $display("dense_layer_sigmoid_forward_top: mismatch");
        $finish;
    end

endmodule
